>>> rtl/ggnh_pkg.sv
// ggnh_pkg: shared types and constants for the greedy geographic next-hop block
// no dependencies; imported by every module under rtl
package ggnh_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COORD_W     = 16;
    localparam int DIST_W      = 2 * COORD_W + 1;
    localparam int DRAIN_W     = 2;
    // drain counter value at which the selection has settled and the sequencer returns to idle
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd3;

    typedef enum logic [1:0] {
        CMD_HELLO  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_IGNORED = 3'd1,
        ST_FULL    = 3'd2,
        ST_FORWARD = 3'd3,
        ST_DIRECT  = 3'd4,
        ST_NOROUTE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    localparam logic [2:0] CFG_SINK_X      = 3'd0;
    localparam logic [2:0] CFG_SINK_Y      = 3'd1;
    localparam logic [2:0] CFG_SINK_ID     = 3'd2;
    localparam logic [2:0] CFG_MIN_ENERGY  = 3'd3;
    localparam logic [2:0] CFG_RADIO_RANGE = 3'd4;

    typedef struct packed {
        logic [7:0]         id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [15:0]        energy;
    } entry_t;

    typedef struct packed {
        logic [7:0]         id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } hop_t;

    // side band that travels with each distance evaluation
    typedef struct packed {
        logic valid;
        logic own;
        logic elig;
    } tag_t;

endpackage

>>> rtl/ggnh_cell.sv
// ggnh_cell: one neighbor table entry in the rotating chain
// depends on ggnh_pkg (entry_t)
module ggnh_cell (
    input  logic             clk,
    input  logic             shift_en,
    input  ggnh_pkg::entry_t shift_in,
    input  logic             wr_en,
    input  ggnh_pkg::entry_t wr_data,
    output ggnh_pkg::entry_t entry_q
);
    import ggnh_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (wr_en)
        begin
            entry_next = wr_data;
        end
        else if (shift_en)
        begin
            entry_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

>>> rtl/ggnh_dist.sv
// ggnh_dist: three-stage squared distance unit (abs diff, square, sum)
// depends on ggnh_pkg (tag_t, hop_t, widths)
module ggnh_dist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ggnh_pkg::tag_t                in_tag,
    input  logic [ggnh_pkg::COORD_W-1:0]  ax,
    input  logic [ggnh_pkg::COORD_W-1:0]  ay,
    input  logic [ggnh_pkg::COORD_W-1:0]  bx,
    input  logic [ggnh_pkg::COORD_W-1:0]  by,
    input  ggnh_pkg::hop_t                in_hop,
    output ggnh_pkg::tag_t                out_tag,
    output logic [ggnh_pkg::DIST_W-1:0]   out_dist,
    output ggnh_pkg::hop_t                out_hop
);
    import ggnh_pkg::*;

    tag_t                 s1_tag_reg, s2_tag_reg, s3_tag_reg;
    hop_t                 s1_hop_reg, s2_hop_reg, s3_hop_reg;
    logic [COORD_W-1:0]   s1_dx_reg, s1_dy_reg;
    logic [2*COORD_W-1:0] s2_dxx_reg, s2_dyy_reg;
    logic [DIST_W-1:0]    s3_dist_reg;
    logic [COORD_W-1:0]   dx_next, dy_next;

    always_comb
    begin
        dx_next = (ax > bx) ? (ax - bx) : (bx - ax);
        dy_next = (ay > by) ? (ay - by) : (by - ay);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= in_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= dx_next;
        s1_dy_reg   <= dy_next;
        s1_hop_reg  <= in_hop;
        s2_dxx_reg  <= s1_dx_reg * s1_dx_reg;
        s2_dyy_reg  <= s1_dy_reg * s1_dy_reg;
        s2_hop_reg  <= s1_hop_reg;
        s3_dist_reg <= {1'b0, s2_dxx_reg} + {1'b0, s2_dyy_reg};
        s3_hop_reg  <= s2_hop_reg;
    end

    assign out_tag  = s3_tag_reg;
    assign out_dist = s3_dist_reg;
    assign out_hop  = s3_hop_reg;

endmodule

>>> rtl/greedy_geographic_next_hop.sv
// greedy_geographic_next_hop: hello and ignored commands give their result strobe in the cycle
// after acceptance; energy updates and route queries keep busy high until their result strobe;
// the block takes no new command while busy, which lasts one full rotation of the cell chain
// past the single distance unit, then the unit's pipeline drain
// reset: asynchronous active low; table contents undefined, entry count zero, control and config
// registers at their defaults; the result strobe lasts one cycle and the receiver cannot stall it
module greedy_geographic_next_hop (
    input  logic        clk,
    input  logic        rst_n,
    // command transaction
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  node_id,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] energy_level,
    // configuration write transaction
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // result transaction, one cycle strobe
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [7:0]  next_hop_id,
    output logic [15:0] next_hop_x,
    output logic [15:0] next_hop_y
);
    import ggnh_pkg::*;

    // configuration registers
    logic [15:0] sink_x_reg, sink_y_reg, min_energy_reg, radio_range_reg;
    logic [7:0]  sink_id_reg;

    // control
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic [DRAIN_W-1:0] drain_reg;
    cmd_t               op_reg;
    logic [7:0]         nid_reg;
    logic [15:0]        en_reg;
    logic [CNT_W-1:0]   count_reg;

    // selection state
    logic [2*COORD_W-1:0] range_sq_reg;
    logic [DIST_W-1:0]    own_reg, best_reg;
    logic                 found_reg;
    hop_t                 pick_reg;

    // result registers
    logic    result_valid_reg;
    status_t status_reg;
    hop_t    hop_reg;

    // decoded controls
    logic   accept, shift_en, feed_scan, finish, hello_store, in_range;
    logic   is_sink, is_full, head_live;
    entry_t cell_q [TABLE_DEPTH];
    entry_t head, head_mod, wr_data;
    tag_t   feed_tag, out_tag;
    logic [COORD_W-1:0] feed_x, feed_y;
    hop_t   feed_hop, out_hop;
    logic [DIST_W-1:0]  out_dist;

    assign cfg_ready = 1'b1;
    assign is_sink   = (node_id == sink_id_reg);
    assign is_full   = (count_reg >= CNT_W'(TABLE_DEPTH));

    // ---------------------------------------------------------------
    // configuration writes, taken at any time; unknown indexes dropped
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_x_reg      <= 16'd0;
            sink_y_reg      <= 16'd0;
            sink_id_reg     <= 8'd0;
            min_energy_reg  <= 16'd3277;
            radio_range_reg <= 16'd4800;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SINK_X:      sink_x_reg      <= cfg_data;
                CFG_SINK_Y:      sink_y_reg      <= cfg_data;
                CFG_SINK_ID:     sink_id_reg     <= cfg_data[7:0];
                CFG_MIN_ENERGY:  min_energy_reg  <= cfg_data;
                CFG_RADIO_RANGE: radio_range_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // sequencer: idle, rotate the chain once, drain the distance unit
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd_t'(cmd))
                        CMD_UPDATE: state_next = is_sink ? S_IDLE : S_SCAN;
                        CMD_QUERY:  state_next = S_SCAN;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        accept      = start && (state_reg == S_IDLE);
        shift_en    = (state_reg == S_SCAN);
        feed_scan   = (state_reg == S_SCAN) && (op_reg == CMD_QUERY);
        finish      = (state_reg == S_DRAIN) && (drain_reg == DRAIN_LAST);
        hello_store = accept && (cmd_t'(cmd) == CMD_HELLO) && !is_sink && !is_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            drain_reg <= '0;
            count_reg <= '0;
            op_reg    <= CMD_HELLO;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= shift_en ? cnt_reg + 1'b1 : '0;
            drain_reg <= (state_reg == S_DRAIN) ? drain_reg + 1'b1 : '0;
            if (hello_store)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (accept)
            begin
                op_reg <= cmd_t'(cmd);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nid_reg      <= node_id;
            en_reg       <= energy_level;
            range_sq_reg <= radio_range_reg * radio_range_reg;
        end
    end

    // ---------------------------------------------------------------
    // cell chain: entry i sits in cell i between scans; during a scan
    // each cell passes to its lower neighbor and the head wraps around
    // to the tail, so at the end of the scan every entry is home again
    // ---------------------------------------------------------------
    assign head      = cell_q[0];
    assign head_live = (CNT_W'(cnt_reg) < count_reg);

    // energy update is applied as the entry passes the head
    always_comb
    begin
        head_mod = head;
        if ((op_reg == CMD_UPDATE) && head_live && (head.id == nid_reg))
        begin
            head_mod.energy = en_reg;
        end
    end

    assign wr_data = '{id: node_id, x: pos_x, y: pos_y, energy: energy_level};

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t cell_in;
        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign cell_in = head_mod;
        end
        else
        begin : g_mid
            assign cell_in = cell_q[i+1];
        end
        ggnh_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .shift_in (cell_in),
            .wr_en    (hello_store && (count_reg[IDX_W-1:0] == IDX_W'(i))),
            .wr_data  (wr_data),
            .entry_q  (cell_q[i])
        );
    end

    // ---------------------------------------------------------------
    // distance unit: own position first (accept cycle), then one entry
    // per scan cycle in table order
    // ---------------------------------------------------------------
    always_comb
    begin
        feed_tag.valid = (accept && (cmd_t'(cmd) == CMD_QUERY)) || feed_scan;
        feed_tag.own   = accept;
        feed_tag.elig  = head_live && (head.energy > min_energy_reg);
        feed_x         = accept ? pos_x : head.x;
        feed_y         = accept ? pos_y : head.y;
        feed_hop       = '{id: head.id, x: head.x, y: head.y};
    end

    ggnh_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (feed_tag),
        .ax       (feed_x),
        .ay       (feed_y),
        .bx       (sink_x_reg),
        .by       (sink_y_reg),
        .in_hop   (feed_hop),
        .out_tag  (out_tag),
        .out_dist (out_dist),
        .out_hop  (out_hop)
    );

    // closest eligible neighbor strictly nearer than us; ties go to the later entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (accept)
        begin
            found_reg <= 1'b0;
        end
        else if (out_tag.valid && !out_tag.own && out_tag.elig && (out_dist < own_reg)
                 && (!found_reg || (out_dist <= best_reg)))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_tag.valid && out_tag.own)
        begin
            own_reg <= out_dist;
        end
        else if (out_tag.valid && out_tag.elig && (out_dist < own_reg)
                 && (!found_reg || (out_dist <= best_reg)))
        begin
            best_reg <= out_dist;
            pick_reg <= out_hop;
        end
    end

    assign in_range = (own_reg <= {1'b0, range_sq_reg});

    // ---------------------------------------------------------------
    // result register: quick answers on accept, scan answers on finish
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= !((cmd_t'(cmd) == CMD_QUERY)
                                  || ((cmd_t'(cmd) == CMD_UPDATE) && !is_sink));
        end
        else
        begin
            result_valid_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hop_reg <= '0;
            case (cmd_t'(cmd))
                CMD_HELLO:
                begin
                    if (is_sink)
                    begin
                        status_reg <= ST_IGNORED;
                    end
                    else if (is_full)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        status_reg <= ST_STORED;
                    end
                end
                default: status_reg <= ST_IGNORED;
            endcase
        end
        else if (finish)
        begin
            if (op_reg == CMD_UPDATE)
            begin
                status_reg <= ST_STORED;
                hop_reg    <= '0;
            end
            else if (in_range)
            begin
                status_reg <= ST_DIRECT;
                hop_reg    <= '{id: sink_id_reg, x: sink_x_reg, y: sink_y_reg};
            end
            else if (found_reg)
            begin
                status_reg <= ST_FORWARD;
                hop_reg    <= pick_reg;
            end
            else
            begin
                status_reg <= ST_NOROUTE;
                hop_reg    <= '0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign next_hop_id  = hop_reg.id;
    assign next_hop_x   = hop_reg.x;
    assign next_hop_y   = hop_reg.y;

endmodule
